@@ rtl/core/register_file_alu_executor_unit_assert.svh @@
// Assertion macros for the register file ALU executor.
`ifndef REGISTER_FILE_ALU_EXECUTOR_UNIT_ASSERT_SVH
`define REGISTER_FILE_ALU_EXECUTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RFAE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define RFAE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RFAE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RFAE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/rfae_pkg.sv @@
package rfae_pkg;

  localparam int OP_W      = 3;
  localparam int IN_IDX_W  = 5;
  localparam int OUT_VAL_W = 32;

  localparam int NUM_REGISTERS_DEF = 32;
  localparam int DATA_WIDTH_DEF    = 32;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD = 3'd4;

  typedef struct packed {
    logic load_instr;
    logic rd_en;
    logic setup;
    logic step;
    logic finish;
    logic wr_en;
  } rfae_cmd_t;

  typedef struct packed {
    logic op_legal;
    logic fast;
  } rfae_stat_t;

endpackage

@@ rtl/core/register_file_alu_executor_unit.sv @@
// Sequence: accept, S_READ, S_SETUP, then the done strobe (S_WRITE) for add, subtract and a
// zero divisor; multiply, divide and remainder pass S_ITER for each bit and S_FIN first.
// A new instruction is taken in the strobe cycle, not while busy; the shared shift-add /
// restoring divide unit retires one bit per cycle.
// Reset (rst, synchronous) clears the controller and the register file valid bits, so
// every register reads zero. Results are strobed on done; the receiver cannot stall.
`include "register_file_alu_executor_unit_assert.svh"
module register_file_alu_executor_unit #(
  parameter int NUM_REGISTERS = rfae_pkg::NUM_REGISTERS_DEF,
  parameter int DATA_WIDTH    = rfae_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rfae_pkg::OP_W-1:0]             op,
  input  logic [rfae_pkg::IN_IDX_W-1:0]         dest_index,
  input  logic [rfae_pkg::IN_IDX_W-1:0]         src1_index,
  input  logic [rfae_pkg::IN_IDX_W-1:0]         src2_index,
  output logic                                  done,
  output logic [rfae_pkg::IN_IDX_W-1:0]         written_index,
  output logic signed [rfae_pkg::OUT_VAL_W-1:0] written_value,
  output logic                                  divide_by_zero
);
  import rfae_pkg::*;

  rfae_cmd_t  cmd;
  rfae_stat_t stat;

  rfae_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  rfae_datapath #(
    .NUM_REGISTERS(NUM_REGISTERS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .dest_index    (dest_index),
    .src1_index    (src1_index),
    .src2_index    (src2_index),
    .written_index (written_index),
    .written_value (written_value),
    .divide_by_zero(divide_by_zero)
  );

  `RFAE_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `RFAE_ASSERT_NXT(a_single_beat, clk, rst, done, !done)
  `RFAE_ASSERT_NXT(a_illegal_dropped, clk, rst, (start && !busy && (op > OP_MOD)), (!busy && !done))
  `RFAE_ASSERT_IMP(a_write_on_done, clk, rst, done, (cmd.wr_en && !cmd.step))

endmodule

@@ rtl/core/rfae_ctrl.sv @@
module rfae_ctrl #(
  parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  rfae_pkg::rfae_stat_t  stat,
  output rfae_pkg::rfae_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);
  import rfae_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             last;

  assign last = (cnt == CNT_W'(DATA_WIDTH - 1));
  assign busy = (state != S_IDLE) && (state != S_WRITE);
  assign done = (state == S_WRITE);

  always_comb begin
    cmd            = '0;
    cmd.load_instr = start && !busy;
    cmd.rd_en      = (state == S_READ);
    cmd.setup      = (state == S_SETUP);
    cmd.step       = (state == S_ITER);
    cmd.finish     = (state == S_FIN);
    cmd.wr_en      = (state == S_WRITE);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE, S_WRITE: begin
        state_next = (start && stat.op_legal) ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cnt_next   = '0;
        state_next = stat.fast ? S_WRITE : S_ITER;
      end
      S_ITER: begin
        cnt_next   = cnt + 1'b1;
        state_next = last ? S_FIN : S_ITER;
      end
      S_FIN: begin
        state_next = S_WRITE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/core/rfae_datapath.sv @@
module rfae_datapath #(
  parameter int NUM_REGISTERS = rfae_pkg::NUM_REGISTERS_DEF,
  parameter int DATA_WIDTH    = rfae_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rfae_pkg::rfae_cmd_t                 cmd,
  output rfae_pkg::rfae_stat_t                stat,
  input  logic [rfae_pkg::OP_W-1:0]           op,
  input  logic [rfae_pkg::IN_IDX_W-1:0]       dest_index,
  input  logic [rfae_pkg::IN_IDX_W-1:0]       src1_index,
  input  logic [rfae_pkg::IN_IDX_W-1:0]       src2_index,
  output logic [rfae_pkg::IN_IDX_W-1:0]       written_index,
  output logic signed [rfae_pkg::OUT_VAL_W-1:0] written_value,
  output logic                                divide_by_zero
);
  import rfae_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int IDX_W = $clog2(NUM_REGISTERS);
  localparam int TAB_N = 2 ** IN_IDX_W;

  logic [IDX_W-1:0] wrap_tab [TAB_N];

  genvar k;
  generate
    for (k = 0; k < TAB_N; k++) begin : g_wrap
      assign wrap_tab[k] = IDX_W'(k % NUM_REGISTERS);
    end
  endgenerate

  logic [W-1:0]             mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] vld;

  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] dest_q;
  logic [IDX_W-1:0] src1_q;
  logic [IDX_W-1:0] src2_q;
  logic [W-1:0]     a_raw;
  logic [W-1:0]     b_raw;
  logic             a_v;
  logic             b_v;
  logic [W-1:0]     a;
  logic [W-1:0]     b;
  logic [W-1:0]     ua;
  logic [W-1:0]     ub;
  logic             b_zero;
  logic             is_divmod;

  logic [W-1:0]     hi;
  logic [W-1:0]     lo;
  logic [W-1:0]     opnd;
  logic             neg_q;
  logic [W-1:0]     res;
  logic             dz_q;

  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ge;
  logic [W-1:0]     fin_val;

  assign a         = a_v ? a_raw : '0;
  assign b         = b_v ? b_raw : '0;
  assign ua        = a[W-1] ? ('0 - a) : a;
  assign ub        = b[W-1] ? ('0 - b) : b;
  assign b_zero    = (b == '0);
  assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);

  assign stat.op_legal = (op <= OP_MOD);
  assign stat.fast     = (op_q == OP_ADD) || (op_q == OP_SUB) || (is_divmod && b_zero);

  assign shifted = {hi, lo[W-1]};
  assign ge      = (shifted >= {1'b0, opnd});
  assign diff    = shifted - {1'b0, opnd};
  assign fin_val = (op_q == OP_DIV) ? lo : hi;

  always_ff @(posedge clk) begin
    if (cmd.load_instr) begin
      op_q   <= op;
      dest_q <= wrap_tab[dest_index];
      src1_q <= wrap_tab[src1_index];
      src2_q <= wrap_tab[src2_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_raw <= mem[src1_q];
      b_raw <= mem[src2_q];
    end
    if (cmd.wr_en) begin
      mem[dest_q] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        a_v <= vld[src1_q];
        b_v <= vld[src2_q];
      end
      if (cmd.wr_en) begin
        vld[dest_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      dz_q  <= 1'b0;
      hi    <= '0;
      neg_q <= 1'b0;
      unique case (op_q)
        OP_ADD: begin
          res <= a + b;
        end
        OP_SUB: begin
          res <= a - b;
        end
        OP_MUL: begin
          lo   <= b;
          opnd <= a;
        end
        default: begin
          if (b_zero) begin
            dz_q <= 1'b1;
            res  <= (op_q == OP_DIV) ? '1 : a;
          end
          lo    <= ua;
          opnd  <= ub;
          neg_q <= (op_q == OP_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
        end
      endcase
    end else if (cmd.step) begin
      if (op_q == OP_MUL) begin
        hi   <= hi + (lo[0] ? opnd : '0);
        lo   <= lo >> 1;
        opnd <= opnd << 1;
      end else if (ge) begin
        hi <= diff[W-1:0];
        lo <= {lo[W-2:0], 1'b1};
      end else begin
        hi <= shifted[W-1:0];
        lo <= {lo[W-2:0], 1'b0};
      end
    end else if (cmd.finish) begin
      res <= neg_q ? ('0 - fin_val) : fin_val;
    end
  end

  assign written_index  = IN_IDX_W'(dest_q);
  assign written_value  = OUT_VAL_W'(res);
  assign divide_by_zero = dz_q;

endmodule

@@ dv/register_file_alu_executor_unit_tb.sv @@
`timescale 1ns / 1ps

module register_file_alu_executor_unit_tb;
  import rfae_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam int RANDOM_INSTRS = 850;
  localparam int DRAIN_CYCLES  = 48;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [IN_IDX_W-1:0] dest;
    logic [IN_IDX_W-1:0] src1;
    logic [IN_IDX_W-1:0] src2;
  } instr_t;

  typedef struct packed {
    logic [IN_IDX_W-1:0]  index;
    logic [OUT_VAL_W-1:0] value;
    logic                 dz;
  } writeback_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [OP_W-1:0]             op = OP_ADD;
  logic [IN_IDX_W-1:0]         dest_index = '0;
  logic [IN_IDX_W-1:0]         src1_index = '0;
  logic [IN_IDX_W-1:0]         src2_index = '0;
  logic                        done;
  logic [IN_IDX_W-1:0]         written_index;
  logic signed [OUT_VAL_W-1:0] written_value;
  logic                        divide_by_zero;

  logic                 took = 1'b0;
  int                   gap_left = 0;
  int                   mismatch_count = 0;
  instr_t               instr_queue[$];
  writeback_t           pending_writes[$];
  logic [OUT_VAL_W-1:0] shadow_regs[32];

  register_file_alu_executor_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .dest_index    (dest_index),
    .src1_index    (src1_index),
    .src2_index    (src2_index),
    .done          (done),
    .written_index (written_index),
    .written_value (written_value),
    .divide_by_zero(divide_by_zero)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic push_instr(input logic [OP_W-1:0] o, input int d, input int s1, input int s2);
    instr_t ins;
    ins.op   = o;
    ins.dest = d[IN_IDX_W-1:0];
    ins.src1 = s1[IN_IDX_W-1:0];
    ins.src2 = s2[IN_IDX_W-1:0];
    instr_queue.push_back(ins);
  endtask

  // Returns 0 for reserved ops, which write nothing.
  function automatic bit execute_instr(input instr_t ins, output writeback_t wb);
    logic [OUT_VAL_W-1:0] a;
    logic [OUT_VAL_W-1:0] b;
    logic [OUT_VAL_W-1:0] mag_a;
    logic [OUT_VAL_W-1:0] mag_b;
    logic [OUT_VAL_W-1:0] part;
    logic [OUT_VAL_W-1:0] res;
    logic                 dz;
    a  = shadow_regs[ins.src1];
    b  = shadow_regs[ins.src2];
    dz = 1'b0;
    wb = '0;
    case (ins.op)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: res = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          dz  = 1'b1;
          res = (ins.op == OP_DIV) ? '1 : a;
        end else begin
          mag_a = a[OUT_VAL_W-1] ? -a : a;
          mag_b = b[OUT_VAL_W-1] ? -b : b;
          if (ins.op == OP_DIV) begin
            part = mag_a / mag_b;
            res  = (a[OUT_VAL_W-1] ^ b[OUT_VAL_W-1]) ? -part : part;
          end else begin
            part = mag_a % mag_b;
            res  = a[OUT_VAL_W-1] ? -part : part;
          end
        end
      end
      default: return 1'b0;
    endcase
    shadow_regs[ins.dest] = res;
    wb.index = ins.dest;
    wb.value = res;
    wb.dz    = dz;
    return 1'b1;
  endfunction

  always @(negedge clk) begin : driver
    instr_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (instr_queue.size() == 0) begin
        start <= 1'b0;
      end else if (instr_queue.size() >= 120 && (instr_queue.size() / 80) % 3 != 0 &&
                   $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(0, 6);
        start <= 1'b0;
      end else begin
        nxt = instr_queue.pop_front();
        op         <= nxt.op;
        dest_index <= nxt.dest;
        src1_index <= nxt.src1;
        src2_index <= nxt.src2;
        start      <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    instr_t     cur;
    writeback_t wb;
    writeback_t exp_wb;
    if (rst) begin
      took <= 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat index=%0d value=%h dz=%b",
                                    written_index, written_value, divide_by_zero));
        end else begin
          exp_wb = pending_writes.pop_front();
          if (written_index !== exp_wb.index) begin
            report_mismatch($sformatf("written_index %0d, expected %0d",
                                      written_index, exp_wb.index));
          end
          if (written_value !== exp_wb.value) begin
            report_mismatch($sformatf("written_value %h, expected %h (index %0d)",
                                      written_value, exp_wb.value, exp_wb.index));
          end
          if (divide_by_zero !== exp_wb.dz) begin
            report_mismatch($sformatf("divide_by_zero %b, expected %b (index %0d)",
                                      divide_by_zero, exp_wb.dz, exp_wb.index));
          end
        end
      end
      took <= start && (busy === 1'b0);
      if (start && busy === 1'b0) begin
        cur.op   = op;
        cur.dest = dest_index;
        cur.src1 = src1_index;
        cur.src2 = src2_index;
        if (execute_instr(cur, wb)) begin
          pending_writes.push_back(wb);
        end
      end
    end
  end

  initial begin : stimulus
    int pick;
    int s;
    foreach (shadow_regs[i]) begin
      shadow_regs[i] = '0;
    end

    push_instr(OP_DIV, 1, 0, 0);
    push_instr(OP_MOD, 31, 0, 0);
    push_instr(OP_SUB, 2, 0, 1);
    push_instr(OP_ADD, 3, 2, 2);
    push_instr(OP_MUL, 4, 3, 3);
    push_instr(OP_MUL, 5, 4, 4);
    push_instr(OP_MUL, 6, 5, 5);
    push_instr(OP_MUL, 7, 6, 6);
    push_instr(OP_MUL, 8, 7, 7);
    push_instr(OP_DIV, 10, 7, 3);
    push_instr(OP_MUL, 11, 7, 10);
    push_instr(OP_SUB, 12, 11, 2);
    push_instr(OP_ADD, 13, 12, 2);
    push_instr(OP_DIV, 14, 11, 1);
    push_instr(OP_MOD, 15, 11, 1);
    push_instr(OP_MOD, 16, 11, 0);
    push_instr(OP_DIV, 17, 12, 0);
    push_instr(OP_DIV, 18, 1, 3);
    push_instr(OP_SUB, 19, 0, 12);
    push_instr(OP_DIV, 20, 19, 3);
    push_instr(OP_MOD, 21, 19, 3);
    push_instr(OP_DIV, 22, 12, 19);
    push_instr(OP_RSVD5, 24, 12, 2);
    push_instr(OP_RSVD6, 1, 2, 3);
    push_instr(OP_RSVD7, 31, 31, 31);
    push_instr(OP_ADD, 31, 31, 12);

    for (int n = 0; n < RANDOM_INSTRS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // x / x keeps nonzero values alive in the file
        s = $urandom_range(0, 31);
        push_instr(OP_DIV, $urandom_range(0, 31), s, s);
      end else begin
        push_instr(pick < 32 ? OP_ADD : pick < 56 ? OP_SUB : pick < 78 ? OP_MUL :
                   pick < 87 ? OP_DIV : pick < 96 ? OP_MOD :
                   pick < 97 ? OP_RSVD5 : pick < 98 ? OP_RSVD6 : OP_RSVD7,
                   $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (instr_queue.size() != 0 || start || pending_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;

    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("PASS register_file_alu_executor_unit");
    end else begin
      $display("FAIL register_file_alu_executor_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL register_file_alu_executor_unit");
    $finish;
  end

endmodule
